FILE: src/ddiv_pkg.sv
// Shared types and constants for the decimal long divider.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ddiv_pkg;

  localparam int unsigned DigitW   = 4;
  localparam int unsigned DivW     = 47;
  localparam int unsigned WorkW    = 51;   // full width of remainder * 10 + digit
  localparam int unsigned OutW     = 50;   // width of working and product fields
  localparam int unsigned STdataW  = 8;
  localparam int unsigned MTdataW  = 152;

  localparam logic [DigitW-1:0] MaxQDigit = 4'd9;
  localparam logic [DivW-1:0]   DivReset  = 47'd1;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_TRIAL  = 3'b010,
    ST_FINISH = 3'b100
  } ddiv_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture a digit and form the working value
    logic step;     // take one trial subtraction
    logic finish;   // write the result and update the running state
  } ddiv_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic trial_go;  // divisor fits and the digit is below nine
    logic out_free;  // output register can take a result this cycle
  } ddiv_stat_t;

endpackage

FILE: src/decimal_long_divider.sv
// Decimal long divider: one quotient digit per dividend digit.
// Each digit takes a load, 0..9 trial subtractions
// through the shared subtractor, a state that sees the trials end, and a write that waits for a free output register;
// one digit in flight at a time, so a new request is taken only after the last result is written.
// Reset (rst_ni low, asynchronous) sets divisor to 1 and clears remainder and state.
// Depends on ddiv_pkg, ddiv_ctrl and ddiv_datapath.
`timescale 1ns / 1ps

module decimal_long_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Divisor write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ddiv_pkg::DivW-1:0]    cfg_data_i,
  // Digit requests
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [ddiv_pkg::STdataW-1:0] s_axis_tdata_i,   // [3:0] digit, [7:4] zero
  input  logic                         s_axis_tlast_i,   // final_digit
  // Results
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [3:0] quotient_digit, [53:4] working_value, [103:54] subtracted,
  // [150:104] new_remainder, [151] zero
  output logic [ddiv_pkg::MTdataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tuser_o,   // quotient_valid
  output logic                         m_axis_tlast_o    // done_res
);
  import ddiv_pkg::*;

  ddiv_cmd_t  cmd;
  ddiv_stat_t stat;

  // Divisor writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  ddiv_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  ddiv_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .digit_i         (s_axis_tdata_i[DigitW-1:0]),
    .final_i         (s_axis_tlast_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: src/ddiv_ctrl.sv
// Sequencing state machine for the decimal long divider.
// Depends on ddiv_pkg; drives command signals into ddiv_datapath.
`timescale 1ns / 1ps

module ddiv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  ddiv_pkg::ddiv_stat_t stat_i,
  output ddiv_pkg::ddiv_cmd_t  cmd_o
);
  import ddiv_pkg::*;

  ddiv_state_e state_q, state_d;

  // Take a request only when no digit is in flight
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        if (stat_i.trial_go) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Assertions
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.finish}))
    else $error("more than one datapath command at once");
  a_load_to_trial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_TRIAL))
    else $error("load not followed by trial phase");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> stat_i.out_free)
    else $error("result written while output register busy");

endmodule

FILE: src/ddiv_datapath.sv
// Datapath of the decimal long divider: divisor register, running remainder,
// shared trial subtractor and output register. Depends on ddiv_pkg.
`timescale 1ns / 1ps

module ddiv_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [ddiv_pkg::DivW-1:0]    cfg_data_i,
  input  logic [ddiv_pkg::DigitW-1:0]  digit_i,
  input  logic                         final_i,
  input  ddiv_pkg::ddiv_cmd_t          cmd_i,
  output ddiv_pkg::ddiv_stat_t         stat_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [ddiv_pkg::MTdataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import ddiv_pkg::*;

  logic [DivW-1:0]    div_q;
  logic [DivW-1:0]    prem_q, prem_d;
  logic               started_q, started_d;
  logic [WorkW-1:0]   work_q;
  logic [WorkW-1:0]   rem_q;
  logic [WorkW-1:0]   prod_q;
  logic [DigitW-1:0]  qd_q;
  logic               last_q;

  logic               out_valid_q;
  logic [MTdataW-1:0] out_data_q;
  logic               out_user_q;
  logic               out_last_q;

  logic [WorkW-1:0]   work_d;
  logic [WorkW:0]     diff;
  logic               fits;
  logic               emit;

  // Working value: remainder * 8 + remainder * 2 + digit
  assign work_d = {1'b0, prem_q, 3'b000} + {3'b000, prem_q, 1'b0}
                + {{(WorkW-DigitW){1'b0}}, digit_i};

  // Shared trial subtractor; no borrow means the divisor fits
  assign diff = {1'b0, rem_q} - {{(WorkW-DivW+1){1'b0}}, div_q};
  assign fits = ~diff[WorkW];

  assign stat_o.trial_go = fits && (qd_q != MaxQDigit);
  assign stat_o.out_free = !out_valid_q || m_axis_tready_i;

  // Digit is shown unless it is a leading zero; the final digit is always shown
  assign emit      = started_q || (qd_q != '0) || last_q;
  assign prem_d    = last_q ? '0 : rem_q[DivW-1:0];
  assign started_d = last_q ? 1'b0 : (started_q || (qd_q != '0));

  // Divisor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DivReset;
    end else if (cfg_valid_i) begin
      div_q <= cfg_data_i;
    end
  end

  // Running state across digits of one dividend
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prem_q    <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.finish) begin
      prem_q    <= prem_d;
      started_q <= started_d;
    end
  end

  // Per-digit working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= work_d;
      rem_q  <= work_d;
      prod_q <= '0;
      qd_q   <= '0;
      last_q <= final_i;
    end else if (cmd_i.step) begin
      rem_q  <= diff[WorkW-1:0];
      prod_q <= prod_q + {{(WorkW-DivW){1'b0}}, div_q};
      qd_q   <= qd_q + 4'd1;
    end
  end

  // Output valid: set on a new result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {1'b0, rem_q[DivW-1:0], prod_q[OutW-1:0], work_q[OutW-1:0], qd_q};
      out_user_q <= emit;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // Assertions
  a_qd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (qd_q != MaxQDigit))
    else $error("trial step past nine");
  a_nonzero_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q[DigitW-1:0] != '0)) |-> out_user_q)
    else $error("nonzero quotient digit suppressed");
  a_last_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_user_q)
    else $error("final digit suppressed");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && last_q) |=> (prem_q == '0) && !started_q)
    else $error("state not cleared after final digit");

endmodule
